// ----- src/sida_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sida_pkg
// Shared types and constants for the signed integer to decimal ASCII block.
// ----------------------------------------------------------------------------
package sida_pkg;

   localparam logic [6:0] CH_ZERO  = 7'd48;
   localparam logic [6:0] CH_MINUS = 7'd45;

   typedef struct packed {
      logic load;
      logic step;
      logic size;
      logic sign_sel;
      logic emit;
   } sida_cmd_type;

   typedef struct packed {
      logic conv_last;
      logic negative;
      logic last_digit;
   } sida_stat_type;

   // decimal digits needed for the magnitude 2^(width-1)
   function automatic int dec_digits(input int width);
      logic [64:0] lim;
      logic [64:0] p;
      int          n;
      lim = 65'd1 << (width - 1);
      p   = 65'd10;
      n   = 1;
      for (int i = 0; i < 20; i++) begin
         if (p <= lim) begin
            n = n + 1;
            p = 65'(p * 65'd10);
         end
      end
      return n;
   endfunction

endpackage

// ----- src/sida_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sida_req_if / sida_rsp_if
// Valid/ready channels: integer beats in, character beats out.
// ----------------------------------------------------------------------------
interface sida_req_if #(
   parameter int VALUE_WIDTH = 32
);
   logic                          valid;
   logic                          ready;
   logic signed [VALUE_WIDTH-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface sida_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] char_code;
   logic       last;

   modport source (output valid, output char_code, output last, input ready);
   modport sink   (input valid, input char_code, input last, output ready);
endinterface

// ----- src/sida_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sida_ctrl
// Sequencer: accept, convert bit by bit, size the text, then emit beats.
// ----------------------------------------------------------------------------
module sida_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output sida_pkg::sida_cmd_type  cmd,
   input  sida_pkg::sida_stat_type stat
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SIZE,
      ST_SIGN,
      ST_DIGITS
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            cmd.step = 1'b1;
            if (stat.conv_last) begin
               state_in = ST_SIZE;
            end
         end
         ST_SIZE: begin
            cmd.size = 1'b1;
            state_in = stat.negative ? ST_SIGN : ST_DIGITS;
         end
         ST_SIGN: begin
            rsp_valid    = 1'b1;
            cmd.sign_sel = 1'b1;
            if (rsp_ready) begin
               state_in = ST_DIGITS;
            end
         end
         ST_DIGITS: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               cmd.emit = 1'b1;
               if (stat.last_digit) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- src/sida_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sida_dp
// Magnitude and BCD shift registers with add-3 correction, digit counter
// and character select.
// ----------------------------------------------------------------------------
module sida_dp #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic signed [VALUE_WIDTH-1:0] value,
   input  sida_pkg::sida_cmd_type        cmd,
   output sida_pkg::sida_stat_type       stat,
   output logic [6:0]                    char_code,
   output logic                          last
);

   localparam int NDIG = sida_pkg::dec_digits(VALUE_WIDTH);
   localparam int BW   = 4 * NDIG;
   localparam int CW   = $clog2(VALUE_WIDTH);
   localparam int LW   = $clog2(NDIG + 1);
   localparam int IW   = $clog2(NDIG);

   logic [VALUE_WIDTH-1:0] mag_ff, mag_in;
   logic [BW-1:0]          bcd_ff, bcd_in;
   logic [CW-1:0]          bit_cnt_ff, bit_cnt_in;
   logic [LW-1:0]          left_ff, left_in;
   logic                   neg_ff, neg_in;

   logic [VALUE_WIDTH-1:0] raw;
   logic [BW-1:0]          adj;
   logic [LW-1:0]          sig_cnt;
   logic [IW-1:0]          dig_idx;
   logic [3:0]             dig;

   assign raw = value;

   always_comb begin
      for (int i = 0; i < NDIG; i++) begin
         adj[4*i +: 4] = (bcd_ff[4*i +: 4] >= 4'd5) ? 4'(bcd_ff[4*i +: 4] + 4'd3)
                                                    : bcd_ff[4*i +: 4];
      end
   end

   always_comb begin
      sig_cnt = LW'(1);
      for (int i = 0; i < NDIG; i++) begin
         if (bcd_ff[4*i +: 4] != 4'd0) begin
            sig_cnt = LW'(i + 1);
         end
      end
   end

   always_comb begin
      mag_in     = mag_ff;
      bcd_in     = bcd_ff;
      bit_cnt_in = bit_cnt_ff;
      left_in    = left_ff;
      neg_in     = neg_ff;
      if (cmd.load) begin
         neg_in     = raw[VALUE_WIDTH-1];
         mag_in     = raw[VALUE_WIDTH-1] ? VALUE_WIDTH'(~raw + 1'b1) : raw;
         bcd_in     = '0;
         bit_cnt_in = '0;
      end
      if (cmd.step) begin
         bcd_in     = {adj[BW-2:0], mag_ff[VALUE_WIDTH-1]};
         mag_in     = {mag_ff[VALUE_WIDTH-2:0], 1'b0};
         bit_cnt_in = CW'(bit_cnt_ff + 1'b1);
      end
      if (cmd.size) begin
         left_in = sig_cnt;
      end
      if (cmd.emit) begin
         left_in = LW'(left_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_cnt_ff <= '0;
         left_ff    <= '0;
         neg_ff     <= 1'b0;
      end else begin
         bit_cnt_ff <= bit_cnt_in;
         left_ff    <= left_in;
         neg_ff     <= neg_in;
      end
      mag_ff <= mag_in;
      bcd_ff <= bcd_in;
   end

   assign dig_idx = IW'(left_ff - 1'b1);
   assign dig     = bcd_ff[4*dig_idx +: 4];

   assign stat.conv_last  = (bit_cnt_ff == CW'(VALUE_WIDTH - 1));
   assign stat.negative   = neg_ff;
   assign stat.last_digit = (left_ff == LW'(1));

   assign char_code = cmd.sign_sel ? sida_pkg::CH_MINUS
                                   : 7'(sida_pkg::CH_ZERO + {3'd0, dig});
   assign last      = cmd.sign_sel ? 1'b0 : stat.last_digit;

endmodule

// ----- src/signed_int_to_decimal_ascii_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_top
// Signed integer in, decimal ASCII text out, one character per beat.
// ----------------------------------------------------------------------------
// Each accepted integer is converted with a shift-and-add-3 binary to BCD
// loop that takes one input bit per cycle over all VALUE_WIDTH bits (32 by
// default), after which the significant digits are counted. The text then
// leaves one character per beat: '-' first for negative values, then the
// digits, most significant first, with last set on the final one. Each
// text is 1 to 11 characters long by default, and a new integer is accepted
// only after the previous text is fully delivered.
module signed_int_to_decimal_ascii_top #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   sida_req_if.sink   req_chan,
   sida_rsp_if.source rsp_chan
);

   sida_pkg::sida_cmd_type  cmd;
   sida_pkg::sida_stat_type stat;

   sida_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   sida_dp #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .value     (req_chan.value),
      .cmd       (cmd),
      .stat      (stat),
      .char_code (rsp_chan.char_code),
      .last      (rsp_chan.last)
   );

endmodule
